[rtl/core/acu_pkg.sv]
// Package for the alarm clock user interface controller.
// Holds screen, knob and symbol codes, item and state structs, shared constants.
// No dependencies.
`default_nettype none

package acu_pkg;

	localparam int ALARM_COUNT_DEF = 2;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;

	localparam logic [15:0] BLINK_PERIOD_RESET  = 16'd500;
	localparam logic [31:0] ALARM_LOCKOUT_RESET = 32'd60000;

	localparam logic REG_BLINK_PERIOD  = 1'b0;
	localparam logic REG_ALARM_LOCKOUT = 1'b1;

	localparam int HOURS_HALF_DAY   = 12;
	localparam int HOURS_MAX        = 23;
	localparam int MINUTES_MAX      = 59;
	localparam int MINUTES_PER_HOUR = 60;

	typedef logic [4:0] sym_t;

	localparam sym_t SYM_ONE   = 5'd1;
	localparam sym_t SYM_TWO   = 5'd2;
	localparam sym_t SYM_BLANK = 5'd10;
	localparam sym_t SYM_A     = 5'd11;
	localparam sym_t SYM_C     = 5'd12;
	localparam sym_t SYM_L     = 5'd13;
	localparam sym_t SYM_O     = 5'd14;
	localparam sym_t SYM_N     = 5'd15;
	localparam sym_t SYM_F     = 5'd16;

	typedef enum logic [2:0] {
		KNOB_NONE  = 3'd0,
		KNOB_UP    = 3'd1,
		KNOB_DOWN  = 3'd2,
		KNOB_PRESS = 3'd3,
		KNOB_LONG  = 3'd4
	} knob_t;

	typedef enum logic [2:0] {
		SCR_CLOCK  = 3'd0,
		SCR_TARGET = 3'd1,
		SCR_ALARM  = 3'd2,
		SCR_HOUR   = 3'd3,
		SCR_MINUTE = 3'd4
	} screen_t;

	typedef enum logic [1:0] {
		TGT_ALARM1 = 2'd0,
		TGT_ALARM2 = 2'd1,
		TGT_CLOCK  = 2'd2
	} target_t;

	typedef struct packed {
		logic [15:0] blink_period_ms;
		logic [31:0] alarm_lockout_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  knob_event;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		sym_t        digit_one;
		sym_t        digit_two;
		sym_t        digit_three;
		sym_t        digit_four;
		logic        colon_lit;
		logic        pm_dot;
		logic        buzzer_sounding;
		logic        clock_write;
		logic [4:0]  write_hour;
		logic [5:0]  write_minute;
		logic [2:0]  ui_screen;
	} result_t;

	typedef struct packed {
		screen_t     screen;
		target_t     target_select;
		logic [4:0]  edit_hour;
		logic [5:0]  edit_minute;
		logic        edit_is_am;
		logic        blink_phase;
		logic [31:0] last_blink_ms;
		logic [31:0] last_trigger_ms;
		logic        buzzer_on;
	} ui_state_t;

	typedef struct packed {
		logic       toggle;
		logic       store;
		logic       slot;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [4:0] match_hour;
		logic [5:0] match_minute;
	} alarm_cmd_t;

	typedef struct packed {
		logic slot_enabled;
		logic any_match;
	} alarm_status_t;

endpackage

`default_nettype wire

[rtl/core/acu_if.sv]
// Item channel interfaces for the alarm clock user interface controller.
// Depends on nothing; payload widths follow the input and result fields.
`default_nettype none

interface acu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  knob_event;
	logic [4:0]  now_hour;
	logic [5:0]  now_minute;
	logic [31:0] now_ms;

	modport source (output valid, knob_event, now_hour, now_minute, now_ms, input ready);
	modport sink (input valid, knob_event, now_hour, now_minute, now_ms, output ready);
endinterface

interface acu_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] digit_one;
	logic [4:0] digit_two;
	logic [4:0] digit_three;
	logic [4:0] digit_four;
	logic       colon_lit;
	logic       pm_dot;
	logic       buzzer_sounding;
	logic       clock_write;
	logic [4:0] write_hour;
	logic [5:0] write_minute;
	logic [2:0] ui_screen;

	modport source (output valid, digit_one, digit_two, digit_three, digit_four, colon_lit,
		pm_dot, buzzer_sounding, clock_write, write_hour, write_minute, ui_screen,
		input ready);
	modport sink (input valid, digit_one, digit_two, digit_three, digit_four, colon_lit,
		pm_dot, buzzer_sounding, clock_write, write_hour, write_minute, ui_screen,
		output ready);
endinterface

`default_nettype wire

[rtl/core/acu_cfg.sv]
// APB-style configuration registers: blink period and alarm lockout.
// Depends on acu_pkg.
`default_nettype none

module acu_cfg import acu_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [15:0] blink_period_q;
	logic [31:0] alarm_lockout_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q  <= BLINK_PERIOD_RESET;
			alarm_lockout_q <= ALARM_LOCKOUT_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_BLINK_PERIOD) begin
				blink_period_q <= pwdata[15:0];
			end else begin
				alarm_lockout_q <= pwdata[31:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_ALARM_LOCKOUT) begin
			prdata = alarm_lockout_q;
		end else begin
			prdata = {16'd0, blink_period_q};
		end
	end

	assign cfg.blink_period_ms  = blink_period_q;
	assign cfg.alarm_lockout_ms = alarm_lockout_q;

endmodule

`default_nettype wire

[rtl/core/acu_alarm.sv]
// Alarm store: enable flag, hour and minute per alarm, with the time match.
// Depends on acu_pkg.
`default_nettype none

module acu_alarm import acu_pkg::*; #(
	parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  we,
	input  wire alarm_cmd_t cmd,
	output alarm_status_t status
);

	localparam int SLOT_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

	logic             enabled_q [ALARM_COUNT];
	logic [4:0]       hour_q    [ALARM_COUNT];
	logic [5:0]       minute_q  [ALARM_COUNT];
	logic [SLOT_W-1:0] idx;

	assign idx = SLOT_W'(cmd.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALARM_COUNT; i++) begin
				enabled_q[i] <= 1'b0;
				hour_q[i]    <= 5'd0;
				minute_q[i]  <= 6'd0;
			end
		end else if (we) begin
			if (cmd.toggle) begin
				enabled_q[idx] <= !enabled_q[idx];
			end
			if (cmd.store) begin
				hour_q[idx]   <= cmd.hour;
				minute_q[idx] <= cmd.minute;
			end
		end
	end

	always_comb begin
		status.slot_enabled = enabled_q[idx];
		status.any_match    = 1'b0;
		for (int i = 0; i < ALARM_COUNT; i++) begin
			if (enabled_q[i] && hour_q[i] == cmd.match_hour
					&& minute_q[i] == cmd.match_minute) begin
				status.any_match = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/acu_ui.sv]
// Screen sequencer and display logic for one item, purely combinational.
// Depends on acu_pkg; alarm status comes from acu_alarm.
`default_nettype none

module acu_ui import acu_pkg::*; #(
	parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
	input  wire in_item_t      item,
	input  wire ui_state_t     cur_state,
	input  wire cfg_t          cfg,
	input  wire alarm_status_t status,
	output ui_state_t     nxt_state,
	output alarm_cmd_t    cmd,
	output result_t       res
);

	typedef struct packed {
		logic [2:0] tens;
		logic [3:0] ones;
	} dec_t;

	function automatic dec_t split_dec(input logic [5:0] v);
		dec_t d;
		d.tens = 3'd0;
		d.ones = v[3:0];
		for (int k = 1; k <= 6; k++) begin
			if (v >= 6'(k * 10)) begin
				d.tens = 3'(k);
				d.ones = 4'(v - 6'(k * 10));
			end
		end
		return d;
	endfunction

	logic        ev_up, ev_dn, ev_press, ev_long;
	screen_t     cur;
	screen_t     next_screen;
	logic [4:0]  hr_c;
	logic [5:0]  mn_c;
	logic [4:0]  h12;
	logic [4:0]  h_step;
	logic [6:0]  m_step;
	logic [4:0]  h24;
	logic [31:0] blink_sum;
	logic [31:0] lock_sum;
	logic        slot;
	dec_t        hour_dec;
	dec_t        min_dec;
	dec_t        now_dec;
	dec_t        h12_dec;

	assign ev_up    = item.knob_event == KNOB_UP;
	assign ev_dn    = item.knob_event == KNOB_DOWN;
	assign ev_press = item.knob_event == KNOB_PRESS;
	assign ev_long  = item.knob_event == KNOB_LONG;
	assign cur      = ev_long ? SCR_TARGET : cur_state.screen;

	assign hr_c = (item.now_hour > 5'(HOURS_MAX)) ? 5'(HOURS_MAX) : item.now_hour;
	assign mn_c = (item.now_minute > 6'(MINUTES_MAX)) ? 6'(MINUTES_MAX) : item.now_minute;
	assign slot = (ALARM_COUNT > 1) && (cur_state.target_select == TGT_ALARM2);

	assign hour_dec = split_dec({1'b0, cur_state.edit_hour});
	assign min_dec  = split_dec(cur_state.edit_minute);
	assign now_dec  = split_dec(mn_c);
	assign h12_dec  = split_dec({1'b0, h12});

	assign blink_sum = {16'd0, cfg.blink_period_ms} + cur_state.last_blink_ms;
	assign lock_sum  = cur_state.last_trigger_ms + cfg.alarm_lockout_ms;

	always_comb begin
		h12 = (hr_c >= 5'(HOURS_HALF_DAY)) ? hr_c - 5'(HOURS_HALF_DAY) : hr_c;
		if (h12 == 5'd0) begin
			h12 = 5'(HOURS_HALF_DAY);
		end
	end

	always_comb begin
		h24 = cur_state.edit_hour;
		if (cur_state.edit_is_am && cur_state.edit_hour == 5'(HOURS_HALF_DAY)) begin
			h24 = 5'd0;
		end else if (!cur_state.edit_is_am && cur_state.edit_hour != 5'(HOURS_HALF_DAY)) begin
			h24 = cur_state.edit_hour + 5'(HOURS_HALF_DAY);
		end
	end

	always_comb begin
		next_screen = cur;
		case (cur)
			SCR_TARGET: begin
				if (ev_press) begin
					next_screen = (cur_state.target_select == TGT_CLOCK) ? SCR_HOUR : SCR_ALARM;
				end
			end
			SCR_ALARM: begin
				if (ev_press) begin
					next_screen = status.slot_enabled ? SCR_HOUR : SCR_CLOCK;
				end
			end
			SCR_HOUR: begin
				if (ev_press) begin
					next_screen = SCR_MINUTE;
				end
			end
			SCR_MINUTE: begin
				if (ev_press) begin
					next_screen = SCR_CLOCK;
				end
			end
			default: begin
				next_screen = SCR_CLOCK;
			end
		endcase
	end

	always_comb begin
		nxt_state        = cur_state;
		nxt_state.screen = next_screen;
		h_step           = cur_state.edit_hour;
		m_step           = {1'b0, cur_state.edit_minute};

		cmd              = '0;
		cmd.slot         = slot;
		cmd.hour         = h24;
		cmd.minute       = cur_state.edit_minute;
		cmd.match_hour   = hr_c;
		cmd.match_minute = mn_c;

		res              = '0;
		res.digit_one    = SYM_BLANK;
		res.digit_two    = SYM_BLANK;
		res.digit_three  = SYM_BLANK;
		res.digit_four   = SYM_BLANK;
		res.ui_screen    = cur;

		case (cur)
			SCR_TARGET: begin
				case (cur_state.target_select)
					TGT_ALARM1: begin
						res.digit_one = SYM_A;
						res.digit_two = SYM_ONE;
					end
					TGT_ALARM2: begin
						res.digit_one = SYM_A;
						res.digit_two = SYM_TWO;
					end
					TGT_CLOCK: begin
						res.digit_one   = SYM_C;
						res.digit_two   = SYM_L;
						res.digit_three = SYM_C;
					end
					default: begin
					end
				endcase
				if (ev_up) begin
					case (cur_state.target_select)
						TGT_ALARM1: nxt_state.target_select = TGT_ALARM2;
						TGT_ALARM2: nxt_state.target_select = TGT_CLOCK;
						TGT_CLOCK:  nxt_state.target_select = TGT_ALARM1;
						default:    nxt_state.target_select = TGT_ALARM2;
					endcase
				end else if (ev_dn) begin
					case (cur_state.target_select)
						TGT_ALARM1: nxt_state.target_select = TGT_CLOCK;
						TGT_ALARM2: nxt_state.target_select = TGT_ALARM1;
						TGT_CLOCK:  nxt_state.target_select = TGT_ALARM2;
						default:    nxt_state.target_select = TGT_CLOCK;
					endcase
				end
			end
			SCR_ALARM: begin
				res.digit_two = SYM_O;
				if (status.slot_enabled) begin
					res.digit_three = SYM_N;
				end else begin
					res.digit_three = SYM_F;
					res.digit_four  = SYM_F;
				end
				cmd.toggle = ev_up || ev_dn;
			end
			SCR_HOUR: begin
				if (cur_state.blink_phase) begin
					res.digit_one = (cur_state.edit_hour >= 5'd10) ? SYM_ONE : SYM_BLANK;
					res.digit_two = {1'b0, hour_dec.ones};
					res.colon_lit = 1'b1;
				end
				res.digit_three = (cur_state.edit_minute >= 6'd10) ?
					{2'b0, min_dec.tens} : SYM_BLANK;
				res.digit_four  = {1'b0, min_dec.ones};
				res.pm_dot      = !cur_state.edit_is_am;
				if (ev_up || ev_dn) begin
					h_step = ev_up ? cur_state.edit_hour + 5'd1 : cur_state.edit_hour - 5'd1;
					if (h_step == 5'(HOURS_HALF_DAY + 1)) begin
						h_step = 5'd1;
					end else if (h_step == 5'd0) begin
						h_step = 5'(HOURS_HALF_DAY);
					end
					nxt_state.edit_hour = h_step;
					if ((ev_up && h_step == 5'(HOURS_HALF_DAY))
							|| (ev_dn && h_step == 5'(HOURS_HALF_DAY - 1))) begin
						nxt_state.edit_is_am = !cur_state.edit_is_am;
					end
				end
			end
			SCR_MINUTE: begin
				res.digit_one = (cur_state.edit_hour >= 5'd10) ? SYM_ONE : SYM_BLANK;
				res.digit_two = {1'b0, hour_dec.ones};
				if (cur_state.blink_phase) begin
					res.digit_three = (cur_state.edit_minute >= 6'd10) ?
						{2'b0, min_dec.tens} : SYM_BLANK;
					res.digit_four  = {1'b0, min_dec.ones};
					res.pm_dot      = !cur_state.edit_is_am;
					res.colon_lit   = 1'b1;
				end
				if (ev_up || ev_dn) begin
					m_step = {1'b0, cur_state.edit_minute} + (ev_up ? 7'd1 : 7'(MINUTES_MAX));
					if (m_step >= 7'(MINUTES_PER_HOUR)) begin
						m_step = m_step - 7'(MINUTES_PER_HOUR);
					end
					nxt_state.edit_minute = m_step[5:0];
				end else if (ev_press) begin
					if (cur_state.target_select == TGT_CLOCK) begin
						res.clock_write  = 1'b1;
						res.write_hour   = h24;
						res.write_minute = cur_state.edit_minute;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			default: begin
				nxt_state.edit_hour   = h12;
				nxt_state.edit_minute = mn_c;
				nxt_state.edit_is_am  = hr_c < 5'(HOURS_HALF_DAY);
				res.colon_lit   = 1'b1;
				res.pm_dot      = hr_c >= 5'(HOURS_HALF_DAY);
				res.digit_one   = (h12 >= 5'd10) ? SYM_ONE : SYM_BLANK;
				res.digit_two   = {1'b0, h12_dec.ones};
				res.digit_three = {2'b0, now_dec.tens};
				res.digit_four  = {1'b0, now_dec.ones};
				if (!(lock_sum > item.now_ms) && status.any_match) begin
					nxt_state.last_trigger_ms = item.now_ms;
					nxt_state.buzzer_on       = 1'b1;
				end
				if (ev_press) begin
					nxt_state.buzzer_on = 1'b0;
				end
			end
		endcase

		if (blink_sum < item.now_ms) begin
			nxt_state.last_blink_ms = item.now_ms;
			nxt_state.blink_phase   = !cur_state.blink_phase;
		end

		res.buzzer_sounding = nxt_state.buzzer_on;
	end

endmodule

`default_nettype wire

[rtl/core/alarm_clock_ui_controller.sv]
// Alarm clock user interface controller, top level.
// Depends on acu_pkg, acu_if, acu_cfg, acu_alarm and acu_ui.
//
// Each input item is one pass of the clock's main loop: a knob event, the
// clock time and a millisecond count. The block returns one result item per
// input item with the four display symbols, colon, PM dot, buzzer state and an
// optional clock write request. An item is registered on entry, evaluated
// combinationally against the interface state and the alarm store, and its
// result lands in an output register; a new item is accepted in every cycle
// while the result side keeps taking items. The user must write the
// configuration registers over the APB port only while the block has no item
// in flight; the block itself does not enforce this.
`default_nettype none

module alarm_clock_ui_controller import acu_pkg::*; #(
	parameter int ALARM_COUNT = ALARM_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	acu_in_if.sink                     in_ch,
	acu_out_if.source                  out_ch
);

	localparam ui_state_t UI_RESET = '{
		screen:          SCR_CLOCK,
		target_select:   TGT_ALARM1,
		edit_hour:       5'(HOURS_HALF_DAY),
		edit_minute:     6'd0,
		edit_is_am:      1'b1,
		blink_phase:     1'b0,
		last_blink_ms:   32'd0,
		last_trigger_ms: 32'd0,
		buzzer_on:       1'b0
	};

	cfg_t          cfg;
	in_item_t      item_s1;
	logic          valid_s1;
	result_t       res_q;
	logic          out_valid_q;
	ui_state_t     ui_q;
	ui_state_t     ui_nxt;
	alarm_cmd_t    cmd;
	alarm_status_t status;
	result_t       res;
	logic          advance;
	logic          in_accept;

	acu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acu_alarm #(.ALARM_COUNT(ALARM_COUNT)) u_alarm (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (advance),
		.cmd    (cmd),
		.status (status)
	);

	acu_ui #(.ALARM_COUNT(ALARM_COUNT)) u_ui (
		.item      (item_s1),
		.cur_state (ui_q),
		.cfg       (cfg),
		.status    (status),
		.nxt_state (ui_nxt),
		.cmd       (cmd),
		.res       (res)
	);

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept   = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ui_q        <= UI_RESET;
		end else begin
			valid_s1    <= in_accept || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && !out_ch.ready);
			if (advance) begin
				ui_q <= ui_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.knob_event <= in_ch.knob_event;
			item_s1.now_hour   <= in_ch.now_hour;
			item_s1.now_minute <= in_ch.now_minute;
			item_s1.now_ms     <= in_ch.now_ms;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.digit_one       = res_q.digit_one;
	assign out_ch.digit_two       = res_q.digit_two;
	assign out_ch.digit_three     = res_q.digit_three;
	assign out_ch.digit_four      = res_q.digit_four;
	assign out_ch.colon_lit       = res_q.colon_lit;
	assign out_ch.pm_dot          = res_q.pm_dot;
	assign out_ch.buzzer_sounding = res_q.buzzer_sounding;
	assign out_ch.clock_write     = res_q.clock_write;
	assign out_ch.write_hour      = res_q.write_hour;
	assign out_ch.write_minute    = res_q.write_minute;
	assign out_ch.ui_screen       = res_q.ui_screen;

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_ch.valid)
		else $error("Evaluated item did not reach the output register.");

	a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ui_q))
		else $error("Interface state changed without an item being evaluated.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (valid_s1 && out_valid_q && !out_ch.ready))
		else $error("Input stalled while a stage had room.");

	a_clock_write_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.clock_write) |-> (out_ch.ui_screen == SCR_MINUTE))
		else $error("Clock write request outside the minute screen.");

	a_write_fields_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.clock_write)
			|-> (out_ch.write_hour == 5'd0 && out_ch.write_minute == 6'd0))
		else $error("Write fields set without a clock write request.");

endmodule

`default_nettype wire
